// ===== sv/otd_pkg.sv =====
// Package for the output-queued switch with tail drop.
// Holds field widths, result kinds, opcodes, register indexes and the FSM type.
// No dependencies.
`timescale 1ns / 1ps

package otd_pkg;

    // Field widths fixed by the interface
    localparam int PORT_W      = 3;
    localparam int KIND_W      = 2;
    localparam int DELAY_W     = 5;
    localparam int CNT_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int LIMIT_W     = 5;
    localparam int ACTIVE_W    = 4;

    // Ports reachable through a 3-bit destination field
    localparam int PORT_SPAN = 8;

    // Largest delay the result field carries
    localparam logic [DELAY_W-1:0] DELAY_MAX = 5'd31;

    // Register reset values
    localparam logic [LIMIT_W-1:0]  QUEUE_LIMIT_RST  = 5'd4;
    localparam logic [ACTIVE_W-1:0] ACTIVE_PORTS_RST = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PORTS = 2'd1;

    // Input opcodes
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_QUEUED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEPART  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ARR,
        S_WALK,
        S_REC,
        S_DEP
    } t_state;

    // Saturating increment of a 32-bit counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== sv/otd_stamp_ram.sv =====
// Arrival slot stamp memory: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module otd_stamp_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write stamp
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/otd_port_table.sv =====
// Per-port queue record memory: head pointer, fill count and link-use count.
// Valid bits make never-written records read as zero. Uses otd_pkg.
`timescale 1ns / 1ps

module otd_port_table #(
    parameter int ENTRIES = 8,
    parameter int HEAD_W  = 4,
    parameter int COUNT_W = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic [HEAD_W-1:0]          o_rd_head,
    output logic [COUNT_W-1:0]         o_rd_count,
    output logic [otd_pkg::CNT_W-1:0]  o_rd_uses,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [HEAD_W-1:0]          i_wr_head,
    input  logic [COUNT_W-1:0]         i_wr_count,
    input  logic [otd_pkg::CNT_W-1:0]  i_wr_uses
);

    localparam int REC_W = HEAD_W + COUNT_W + otd_pkg::CNT_W;

    logic [REC_W-1:0]   mem [ENTRIES];
    logic [REC_W-1:0]   r_rd_data;
    logic               r_rd_valid;
    logic [ENTRIES-1:0] r_valid;

    // Write record
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_head, i_wr_count, i_wr_uses};
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Track written records; an unwritten record reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_head  = r_rd_valid ? r_rd_data[REC_W-1 -: HEAD_W] : '0;
    assign o_rd_count = r_rd_valid ? r_rd_data[otd_pkg::CNT_W +: COUNT_W] : '0;
    assign o_rd_uses  = r_rd_valid ? r_rd_data[otd_pkg::CNT_W-1:0] : '0;

endmodule

// ===== sv/output_queue_switch_tail_drop_core.sv =====
// Output-queued switch with tail drop: top level with the controller and counters.
// Uses otd_pkg, otd_port_table and otd_stamp_ram.
`timescale 1ns / 1ps

// An item is taken when i_start is high and o_busy is low. An arrival reads the
// destination record, is decided in S_ARR and its single result is registered
// from S_ARR onto the result ports. A tick walks the active ports
// 0 to min(active_ports, PORTS, 8)-1 one at a time: an empty port is skipped
// in S_WALK, a non-empty port passes S_WALK (port record read), S_REC (stamp
// read) and S_DEP (write-back), and a last S_WALK step closes the slot, so
// o_busy stays high until the walk is back in S_IDLE. The walk is set
// by the single read port of the port record memory and the dependent stamp
// read that follows it. Departure results never come on back-to-back cycles.
// Results are strobed by o_res_valid for one cycle and cannot be held off.
// Queue records use valid bits, so there is no clearing pass after reset.
module output_queue_switch_tail_drop_core #(
    parameter int PORTS       = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Item channel
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_op,
    input  logic [otd_pkg::PORT_W-1:0]       i_dest_port,
    // Configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [otd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [otd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Result channel
    output logic                             o_res_valid,
    output logic [otd_pkg::KIND_W-1:0]       o_kind,
    output logic [otd_pkg::PORT_W-1:0]       o_port,
    output logic [otd_pkg::DELAY_W-1:0]      o_delay,
    output logic [otd_pkg::CNT_W-1:0]        o_link_uses,
    output logic [otd_pkg::CNT_W-1:0]        o_drop_total,
    output logic [otd_pkg::CNT_W-1:0]        o_arrival_total,
    output logic                             o_last
);

    // Only ports a 3-bit destination can reach ever hold packets
    localparam int NQ = (PORTS < otd_pkg::PORT_SPAN) ? PORTS : otd_pkg::PORT_SPAN;
    localparam int PW = $clog2(NQ);
    localparam int WW = $clog2(NQ + 1);
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = HW + 1;
    localparam int AW = $clog2(NQ * QUEUE_DEPTH);
    localparam int LW = (CW > otd_pkg::LIMIT_W) ? CW : otd_pkg::LIMIT_W;
    localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);

    localparam int CNT_W = otd_pkg::CNT_W;

    // Configuration registers
    logic [otd_pkg::LIMIT_W-1:0]  r_queue_limit;
    logic [otd_pkg::ACTIVE_W-1:0] r_active;

    // Controller state
    otd_pkg::t_state r_state, n_state;
    logic [WW-1:0]      r_p, n_p;
    logic [otd_pkg::PORT_W-1:0] r_dest, n_dest;
    logic [HW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CNT_W-1:0]   r_uses, n_uses;
    logic [CNT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]   r_drops, n_drops;
    logic [CNT_W-1:0]   r_arrivals, n_arrivals;
    logic [NQ-1:0]      r_pend, n_pend;

    // Result registers
    logic                          r_res_valid, n_res_valid;
    logic [otd_pkg::KIND_W-1:0]    r_kind, n_kind;
    logic [otd_pkg::PORT_W-1:0]    r_port, n_port;
    logic [otd_pkg::DELAY_W-1:0]   r_delay, n_delay;
    logic [CNT_W-1:0]              r_link_uses, n_link_uses;
    logic [CNT_W-1:0]              r_drop_total, n_drop_total;
    logic [CNT_W-1:0]              r_arrival_total, n_arrival_total;
    logic                          r_last, n_last;

    // Memory ports
    logic           pt_rd_en;
    logic [PW-1:0]  pt_rd_addr;
    logic [HW-1:0]  pt_rd_head;
    logic [CW-1:0]  pt_rd_count;
    logic [CNT_W-1:0] pt_rd_uses;
    logic           pt_wr_en;
    logic [PW-1:0]  pt_wr_addr;
    logic [HW-1:0]  pt_wr_head;
    logic [CW-1:0]  pt_wr_count;
    logic [CNT_W-1:0] pt_wr_uses;
    logic           st_rd_en;
    logic [AW-1:0]  st_rd_addr;
    logic [CNT_W-1:0] st_rd_data;
    logic           st_wr_en;
    logic [AW-1:0]  st_wr_addr;

    // Derived limits and helpers
    logic [otd_pkg::ACTIVE_W-1:0] lim4;
    logic [WW-1:0]    lim_w;
    logic [LW-1:0]    lim_q;
    logic [LW-1:0]    ql_ext;
    logic [SW-1:0]    tail_sum;
    logic [HW-1:0]    tail;
    logic             port_ok;
    logic             port_known;
    logic             full;
    logic [CNT_W-1:0] diff;
    logic [NQ-1:0]    later;

    otd_port_table #(
        .ENTRIES (NQ),
        .HEAD_W  (HW),
        .COUNT_W (CW)
    ) u_port_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (pt_rd_en),
        .i_rd_addr  (pt_rd_addr),
        .o_rd_head  (pt_rd_head),
        .o_rd_count (pt_rd_count),
        .o_rd_uses  (pt_rd_uses),
        .i_wr_en    (pt_wr_en),
        .i_wr_addr  (pt_wr_addr),
        .i_wr_head  (pt_wr_head),
        .i_wr_count (pt_wr_count),
        .i_wr_uses  (pt_wr_uses)
    );

    otd_stamp_ram #(
        .DEPTH (NQ * QUEUE_DEPTH),
        .WIDTH (CNT_W)
    ) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (r_slot),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    // Configuration writes; accept only while no item is being worked on
    assign o_cfg_ready = (r_state == otd_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= otd_pkg::QUEUE_LIMIT_RST;
            r_active      <= otd_pkg::ACTIVE_PORTS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                otd_pkg::REG_QUEUE_LIMIT:  r_queue_limit <= i_cfg_data;
                otd_pkg::REG_ACTIVE_PORTS: r_active <= i_cfg_data[otd_pkg::ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective port count and queue limit
    always_comb begin
        lim4   = (r_active > otd_pkg::ACTIVE_W'(NQ)) ? otd_pkg::ACTIVE_W'(NQ) : r_active;
        lim_w  = WW'(lim4);
        ql_ext = LW'(r_queue_limit);
        lim_q  = (ql_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : ql_ext;
    end

    // Arrival checks and tail position
    always_comb begin
        port_ok    = {1'b0, r_dest} < lim4;
        port_known = {1'b0, r_dest} < otd_pkg::ACTIVE_W'(NQ);
        full       = LW'(pt_rd_count) >= lim_q;
        tail_sum   = SW'(pt_rd_head) + SW'(pt_rd_count);
        tail       = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : HW'(tail_sum);
    end

    // Ports after the current one that still hold packets
    always_comb begin
        for (int j = 0; j < NQ; j++) begin
            later[j] = r_pend[j] && (WW'(j) > r_p) && (WW'(j) < lim_w);
        end
    end

    assign diff = r_slot - st_rd_data + CNT_W'(1);

    // Next state and memory control
    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_dest      = r_dest;
        n_head      = r_head;
        n_count     = r_count;
        n_uses      = r_uses;
        n_slot      = r_slot;
        n_drops     = r_drops;
        n_arrivals  = r_arrivals;
        n_pend      = r_pend;

        n_res_valid     = 1'b0;
        n_kind          = r_kind;
        n_port          = r_port;
        n_delay         = r_delay;
        n_link_uses     = r_link_uses;
        n_drop_total    = r_drop_total;
        n_arrival_total = r_arrival_total;
        n_last          = r_last;

        pt_rd_en    = 1'b0;
        pt_rd_addr  = r_p[PW-1:0];
        pt_wr_en    = 1'b0;
        pt_wr_addr  = r_p[PW-1:0];
        pt_wr_head  = r_head;
        pt_wr_count = r_count;
        pt_wr_uses  = r_uses;
        st_rd_en    = 1'b0;
        st_rd_addr  = AW'(AW'(r_p[PW-1:0]) * AW'(QUEUE_DEPTH)) + AW'(pt_rd_head);
        st_wr_en    = 1'b0;
        st_wr_addr  = AW'(AW'(r_dest[PW-1:0]) * AW'(QUEUE_DEPTH)) + AW'(tail);

        case (r_state)
            otd_pkg::S_IDLE: begin
                // Take an item and fetch the destination record for an arrival
                if (i_start) begin
                    if (i_op == otd_pkg::OP_ARRIVAL) begin
                        n_dest     = i_dest_port;
                        n_arrivals = otd_pkg::sat_inc(r_arrivals);
                        pt_rd_en   = 1'b1;
                        pt_rd_addr = i_dest_port[PW-1:0];
                        n_state    = otd_pkg::S_ARR;
                    end else begin
                        n_p     = '0;
                        n_state = otd_pkg::S_WALK;
                    end
                end
            end
            otd_pkg::S_ARR: begin
                // Queue the stamp or drop the packet
                n_res_valid     = 1'b1;
                n_port          = r_dest;
                n_delay         = '0;
                n_last          = 1'b1;
                n_arrival_total = r_arrivals;
                if (port_ok && !full) begin
                    st_wr_en    = 1'b1;
                    pt_wr_en    = 1'b1;
                    pt_wr_addr  = r_dest[PW-1:0];
                    pt_wr_head  = pt_rd_head;
                    pt_wr_count = pt_rd_count + CW'(1);
                    pt_wr_uses  = pt_rd_uses;
                    n_pend[r_dest[PW-1:0]] = 1'b1;
                    n_kind       = otd_pkg::KIND_QUEUED;
                    n_link_uses  = pt_rd_uses;
                    n_drop_total = r_drops;
                end else begin
                    n_drops      = otd_pkg::sat_inc(r_drops);
                    n_kind       = otd_pkg::KIND_DROPPED;
                    n_link_uses  = port_known ? pt_rd_uses : '0;
                    n_drop_total = n_drops;
                end
                n_state = otd_pkg::S_IDLE;
            end
            otd_pkg::S_WALK: begin
                // Skip empty ports, fetch the record of a busy one, close the slot at the end
                if (r_p >= lim_w) begin
                    n_slot  = r_slot + CNT_W'(1);
                    n_state = otd_pkg::S_IDLE;
                end else if (!r_pend[r_p[PW-1:0]]) begin
                    n_p = r_p + WW'(1);
                end else begin
                    pt_rd_en = 1'b1;
                    n_state  = otd_pkg::S_REC;
                end
            end
            otd_pkg::S_REC: begin
                // Hold the record and fetch the head stamp
                n_head   = pt_rd_head;
                n_count  = pt_rd_count;
                n_uses   = pt_rd_uses;
                st_rd_en = 1'b1;
                n_state  = otd_pkg::S_DEP;
            end
            otd_pkg::S_DEP: begin
                // Send the head packet and write back the advanced record
                pt_wr_en    = 1'b1;
                pt_wr_head  = (r_head == HEAD_LAST) ? '0 : r_head + HW'(1);
                pt_wr_count = r_count - CW'(1);
                pt_wr_uses  = otd_pkg::sat_inc(r_uses);
                if (r_count == CW'(1)) begin
                    n_pend[r_p[PW-1:0]] = 1'b0;
                end
                n_res_valid     = 1'b1;
                n_kind          = otd_pkg::KIND_DEPART;
                n_port          = otd_pkg::PORT_W'(r_p);
                n_delay         = (diff > CNT_W'(otd_pkg::DELAY_MAX)) ? otd_pkg::DELAY_MAX
                                                                       : diff[otd_pkg::DELAY_W-1:0];
                n_link_uses     = pt_wr_uses;
                n_drop_total    = r_drops;
                n_arrival_total = r_arrivals;
                n_last          = !(|later);
                n_p             = r_p + WW'(1);
                n_state         = otd_pkg::S_WALK;
            end
            default: begin
                n_state = otd_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= otd_pkg::S_IDLE;
            r_p         <= '0;
            r_slot      <= '0;
            r_drops     <= '0;
            r_arrivals  <= '0;
            r_pend      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p         <= n_p;
            r_slot      <= n_slot;
            r_drops     <= n_drops;
            r_arrivals  <= n_arrivals;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dest          <= n_dest;
        r_head          <= n_head;
        r_count         <= n_count;
        r_uses          <= n_uses;
        r_kind          <= n_kind;
        r_port          <= n_port;
        r_delay         <= n_delay;
        r_link_uses     <= n_link_uses;
        r_drop_total    <= n_drop_total;
        r_arrival_total <= n_arrival_total;
        r_last          <= n_last;
    end

    assign o_busy          = (r_state != otd_pkg::S_IDLE);
    assign o_res_valid     = r_res_valid;
    assign o_kind          = r_kind;
    assign o_port          = r_port;
    assign o_delay         = r_delay;
    assign o_link_uses     = r_link_uses;
    assign o_drop_total    = r_drop_total;
    assign o_arrival_total = r_arrival_total;
    assign o_last          = r_last;

endmodule

// ===== sv/otd_checker.sv =====
// Port-level checks for the output-queued switch, bound to the top level.
// Uses otd_pkg.
`timescale 1ns / 1ps

module otd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          i_op,
    input logic                          o_res_valid,
    input logic [otd_pkg::KIND_W-1:0]    o_kind,
    input logic [otd_pkg::DELAY_W-1:0]   o_delay,
    input logic                          o_last
);

    // A transfer makes the block busy on the next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy) |=> o_busy)
        else $error("block not busy after item transfer");

    // An arrival transfer is followed by its result
    a_arrival_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy && i_op == otd_pkg::OP_ARRIVAL) |-> ##2 o_res_valid)
        else $error("arrival result missing");

    // Arrival results are always the final result of their item
    a_arrival_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind != otd_pkg::KIND_DEPART) |-> o_last)
        else $error("arrival result without last");

    // A departure never reports a zero delay
    a_depart_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == otd_pkg::KIND_DEPART) |-> o_delay != '0)
        else $error("departure with zero delay");

    // Results never come on back-to-back cycles
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("results on consecutive cycles");

endmodule

bind output_queue_switch_tail_drop_core otd_checker u_otd_checker (.*);
